/* rtl/core/bap_pkg.sv */
// Package for the 3x3 block-average pixelation block.
// Payload structs, register indexes, reset values and arithmetic constants.
// No dependencies.
package bap_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int CFG_W       = 11;
    localparam int CFG_IDX_W   = 2;
    localparam int POS_W       = 10;
    localparam int CHAN_W      = 8;
    localparam int SUM_W       = 12;
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    // floor(s * RECIP_NINE / 2**16) == floor(s / 9) for every 12-bit s
    localparam logic [RECIP_W-1:0] RECIP_NINE = 13'd7282;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic KIND_PASS  = 1'b0;
    localparam logic KIND_BLOCK = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic              kind;
        logic [POS_W-1:0]  pos_x;
        logic [POS_W-1:0]  pos_y;
        logic [CHAN_W-1:0] out_red;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_blue;
    } t_result;

    typedef struct packed {
        logic [SUM_W-1:0] r;
        logic [SUM_W-1:0] g;
        logic [SUM_W-1:0] b;
    } t_sums;

endpackage

/* rtl/core/bap_sum_ram.sv */
// Block-column sum memory: one write port, one read port, registered read data.
// Depends on bap_pkg for the sum struct.
module bap_sum_ram #(
    parameter int DEPTH = bap_pkg::MAX_WIDTH_DEF / 3,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  i_clk,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output bap_pkg::t_sums        o_rd_data,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  bap_pkg::t_sums        i_wr_data
);
    import bap_pkg::*;

    t_sums r_mem [DEPTH];
    t_sums r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/core/block_average_pixelate_3x3.sv */
// 3x3 block-average pixelation of a raster-order RGB stream.
// A taken pixel passes the stage-1 register, then the output register. Throughput: one
// pixel per cycle unless back-pressure stalls, set by the sum memory read-modify-write
// (registered read, write-back forwarded to following pixels of the same block column).
// Reset: counts clear, dimensions go to 640x480; the sum memory is not cleared
// because each block's top-left pixel loads its entry.
module block_average_pixelate_3x3 #(
    parameter int MAX_WIDTH  = bap_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bap_pkg::MAX_HEIGHT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  bap_pkg::t_pixel                 i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output bap_pkg::t_result                o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [bap_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [bap_pkg::CFG_W-1:0]       i_cfg_data
);
    import bap_pkg::*;

    localparam int DEPTH = MAX_WIDTH / 3;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int PW    = SUM_W + RECIP_W;

    function automatic logic [WW-1:0] clamp_w(logic [CFG_W-1:0] v);
        logic [WW-1:0] res;
        if (v == '0) begin
            res = WW'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            res = WW'(MAX_WIDTH);
        end else begin
            res = WW'(v);
        end
        return res;
    endfunction

    function automatic logic [HW-1:0] clamp_h(logic [CFG_W-1:0] v);
        logic [HW-1:0] res;
        if (v == '0) begin
            res = HW'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            res = HW'(MAX_HEIGHT);
        end else begin
            res = HW'(v);
        end
        return res;
    endfunction

    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [CW-1:0] r_col, n_col, r_xs, n_xs;
    logic [1:0]    r_cx, n_cx, r_cy, n_cy;
    logic [AW-1:0] r_bc, n_bc;
    logic [RW-1:0] r_row, n_row, r_ys, n_ys;

    logic          r_s1_valid;
    logic          r_s1_inblock;
    logic          r_s1_first;
    logic          r_s1_last;
    logic [AW-1:0] r_s1_bc;
    t_pixel        r_s1_pix;
    logic [POS_W-1:0] r_s1_px;
    logic [POS_W-1:0] r_s1_py;
    logic          r_fwd;
    t_sums         r_fwd_sum;

    logic          r_out_valid;
    t_result       r_out;

    logic          cfg_write;
    logic          cfg_restart;
    logic          in_accept;
    logic          in_block;
    logic          blk_first;
    logic          blk_last;
    logic          s1_emit;
    logic          s1_move;
    logic          s1_write;
    t_sums         rd_sums;
    t_sums         base_sums;
    t_sums         new_sums;
    logic [PW-1:0] prod_r, prod_g, prod_b;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign cfg_restart = cfg_write && ((i_cfg_index == REG_IMAGE_WIDTH)
                                    || (i_cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= clamp_w(CFG_W'(RESET_WIDTH));
            r_h <= clamp_h(CFG_W'(RESET_HEIGHT));
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_w <= clamp_w(i_cfg_data);
                REG_IMAGE_HEIGHT: r_h <= clamp_h(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign s1_emit    = !r_s1_inblock || r_s1_last;
    assign s1_move    = r_s1_valid && (!s1_emit || !r_out_valid || i_out_ready);
    assign s1_write   = s1_move && r_s1_inblock;
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_accept  = i_in_valid && o_in_ready;

    assign in_block  = ((WW+1)'(r_xs) + (WW+1)'(3) <= (WW+1)'(r_w))
                    && ((HW+1)'(r_ys) + (HW+1)'(3) <= (HW+1)'(r_h));
    assign blk_first = (r_cx == 2'd0) && (r_cy == 2'd0);
    assign blk_last  = (r_cx == 2'd2) && (r_cy == 2'd2);

    always_comb begin
        n_col = r_col;
        n_cx  = r_cx;
        n_bc  = r_bc;
        n_xs  = r_xs;
        n_row = r_row;
        n_cy  = r_cy;
        n_ys  = r_ys;
        if ((WW+1)'(r_col) + (WW+1)'(1) >= (WW+1)'(r_w)) begin
            n_col = '0;
            n_cx  = '0;
            n_bc  = '0;
            n_xs  = '0;
            if ((HW+1)'(r_row) + (HW+1)'(1) >= (HW+1)'(r_h)) begin
                n_row = '0;
                n_cy  = '0;
                n_ys  = '0;
            end else begin
                n_row = r_row + RW'(1);
                if (r_cy == 2'd2) begin
                    n_cy = '0;
                    n_ys = r_ys + RW'(3);
                end else begin
                    n_cy = r_cy + 2'd1;
                end
            end
        end else begin
            n_col = r_col + CW'(1);
            if (r_cx == 2'd2) begin
                n_cx = '0;
                n_bc = r_bc + AW'(1);
                n_xs = r_xs + CW'(3);
            end else begin
                n_cx = r_cx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_restart) begin
            r_col <= '0;
            r_cx  <= '0;
            r_bc  <= '0;
            r_xs  <= '0;
            r_row <= '0;
            r_cy  <= '0;
            r_ys  <= '0;
        end else if (in_accept) begin
            r_col <= n_col;
            r_cx  <= n_cx;
            r_bc  <= n_bc;
            r_xs  <= n_xs;
            r_row <= n_row;
            r_cy  <= n_cy;
            r_ys  <= n_ys;
        end
    end

    bap_sum_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_sum_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (r_bc),
        .o_rd_data (rd_sums),
        .i_wr_en   (s1_write),
        .i_wr_addr (r_s1_bc),
        .i_wr_data (new_sums)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_inblock <= in_block;
            r_s1_first   <= blk_first;
            r_s1_last    <= blk_last;
            r_s1_bc      <= r_bc;
            r_s1_pix     <= i_in_data;
            r_s1_px      <= in_block ? POS_W'(r_xs) : POS_W'(r_col);
            r_s1_py      <= in_block ? POS_W'(r_ys) : POS_W'(r_row);
            r_fwd        <= s1_write && (r_s1_bc == r_bc);
            r_fwd_sum    <= new_sums;
        end
    end

    assign base_sums = r_fwd ? r_fwd_sum : rd_sums;

    always_comb begin
        if (r_s1_first) begin
            new_sums.r = SUM_W'(r_s1_pix.red);
            new_sums.g = SUM_W'(r_s1_pix.green);
            new_sums.b = SUM_W'(r_s1_pix.blue);
        end else begin
            new_sums.r = base_sums.r + SUM_W'(r_s1_pix.red);
            new_sums.g = base_sums.g + SUM_W'(r_s1_pix.green);
            new_sums.b = base_sums.b + SUM_W'(r_s1_pix.blue);
        end
    end

    assign prod_r = PW'(new_sums.r) * PW'(RECIP_NINE);
    assign prod_g = PW'(new_sums.g) * PW'(RECIP_NINE);
    assign prod_b = PW'(new_sums.b) * PW'(RECIP_NINE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && s1_emit) begin
            r_out.pos_x <= r_s1_px;
            r_out.pos_y <= r_s1_py;
            if (r_s1_inblock) begin
                r_out.kind      <= KIND_BLOCK;
                r_out.out_red   <= prod_r[RECIP_SHIFT +: CHAN_W];
                r_out.out_green <= prod_g[RECIP_SHIFT +: CHAN_W];
                r_out.out_blue  <= prod_b[RECIP_SHIFT +: CHAN_W];
            end else begin
                r_out.kind      <= KIND_PASS;
                r_out.out_red   <= r_s1_pix.red;
                r_out.out_green <= r_s1_pix.green;
                r_out.out_blue  <= r_s1_pix.blue;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
